// File: hw/rtl/integer_to_text_in_symbol_base_unit_assert.svh
// Assertion macros shared by the integer-to-text RTL modules.
`ifndef INTEGER_TO_TEXT_IN_SYMBOL_BASE_UNIT_ASSERT_SVH
`define INTEGER_TO_TEXT_IN_SYMBOL_BASE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define ITSB_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset.
`define ITSB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/itsb_pkg.sv
// Package: widths, codes, FSM states and divider request/response types.
package itsb_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned SYMTAB_W   = 64;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CFG_IDX_W  = 2;

  // Divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_CYCLES = VALUE_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [SYM_W-1:0]   SIGN_CHAR   = 8'h2D;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX  = 2'd0,
    REG_SYM_LO = 2'd1,
    REG_SYM_HI = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hw/rtl/itsb_if.sv
// Valid/ready channel interfaces for the input integer and the output characters.
interface itsb_in_if;
  import itsb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itsb_out_if;
  import itsb_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// File: hw/rtl/itsb_div.sv
// Iterative restoring divider: 32-bit dividend by a small radix, 8 bits per cycle.
`include "integer_to_text_in_symbol_base_unit_assert.svh"

module itsb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  itsb_pkg::div_req_t  req,
  output itsb_pkg::div_rsp_t  rsp
);
  import itsb_pkg::*;

  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   divisor_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 last_step;

  assign last_step = (step_r == DIV_CNT_W'(DIV_CYCLES - 1));

  // quo_r shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] rem;
    logic [RADIX_W-1:0] t;
    q   = quo_r;
    rem = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {rem, q[VALUE_W-1]};
      q = {q[VALUE_W-2:0], 1'b0};
      if (t >= divisor_r) begin
        rem  = DIGIT_W'(t - divisor_r);
        q[0] = 1'b1;
      end else begin
        rem = t[DIGIT_W-1:0];
      end
    end
    quo_nxt = q;
    rem_nxt = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `ITSB_ASSERT_NOW(a_div_no_restart, req.start, !busy_r, "divider started while busy")
  `ITSB_ASSERT_NEXT(a_div_done_after_last, busy_r && last_step && !req.start, done_r,
                    "divider missed its done pulse")

endmodule

// File: hw/rtl/integer_to_text_in_symbol_base_unit.sv
// Integer-to-text unit: one signed 32-bit value in, its text in the configured radix
// out, one character per beat, most significant first, last beat flagged. A negative
// value leads with '-', zero gives the digit-0 symbol. Digits come from a single
// iterative divider, one division per digit; the characters then leave one per cycle
// while the output is ready. The unit takes the next value once the last character
// of the current one is in the output register. The radix in use is clamped to
// 2..16; write configuration only while idle.
`include "integer_to_text_in_symbol_base_unit_assert.svh"

module integer_to_text_in_symbol_base_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  itsb_in_if.sink                          in_ch,
  itsb_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [itsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itsb_pkg::SYMTAB_W-1:0]    cfg_wdata
);
  import itsb_pkg::*;

  state_t               state_r, state_nxt;
  logic [RADIX_W-1:0]   radix_r;
  logic [SYMTAB_W-1:0]  sym_lo_r;
  logic [SYMTAB_W-1:0]  sym_hi_r;
  logic [DIGIT_W-1:0]   stack_r [MAX_DIGITS];
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic [SYM_W-1:0]     out_symbol_r;
  logic                 out_last_r;

  logic                 accept;
  logic                 load_ok;
  logic                 in_ready;
  logic                 div_start;
  logic                 load_sign;
  logic                 load_digit;
  logic                 in_neg;
  logic [VALUE_W-1:0]   in_mag;
  logic [RADIX_W-1:0]   eff_radix;
  logic [CNT_W-1:0]     rd_idx;
  logic [DIGIT_W-1:0]   rd_digit;
  logic [SYM_W-1:0]     rd_symbol;
  logic                 more_digits;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign accept  = in_ch.valid && in_ready;
  assign load_ok = !out_valid_r || out_ch.ready;
  assign in_neg  = in_ch.value[VALUE_W-1];
  assign in_mag  = in_neg ? (VALUE_W'(0) - VALUE_W'(in_ch.value)) : VALUE_W'(in_ch.value);

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_r;
    end
  end

  // top of digit stack and its symbol byte
  assign rd_idx      = cnt_r - 1'b1;
  assign rd_digit    = stack_r[rd_idx[$clog2(MAX_DIGITS)-1:0]];
  assign rd_symbol   = rd_digit[DIGIT_W-1] ? sym_hi_r[rd_digit[DIGIT_W-2:0]*SYM_W +: SYM_W]
                                           : sym_lo_r[rd_digit[DIGIT_W-2:0]*SYM_W +: SYM_W];
  assign more_digits = (div_rsp.quotient != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done && !more_digits) begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (load_ok) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_ok && cnt_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_ch.valid;
      end
      S_DIV:   div_start  = div_rsp.done && more_digits;
      S_SIGN:  load_sign  = load_ok;
      S_EMIT:  load_digit = load_ok;
      default: ;
    endcase
  end

  assign div_req.start    = div_start;
  assign div_req.dividend = accept ? in_mag : div_rsp.quotient;
  assign div_req.divisor  = eff_radix;

  itsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RADIX_RESET;
      sym_lo_r    <= '0;
      sym_hi_r    <= '0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX:  radix_r  <= cfg_wdata[RADIX_W-1:0];
          REG_SYM_LO: sym_lo_r <= cfg_wdata;
          REG_SYM_HI: sym_hi_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        cnt_r <= '0;
        neg_r <= in_neg;
      end else if (state_r == S_DIV && div_rsp.done) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (load_digit) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (load_sign || load_digit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: digit stack and output character
  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_rsp.done) begin
      stack_r[cnt_r[$clog2(MAX_DIGITS)-1:0]] <= div_rsp.remainder;
    end
    if (load_sign) begin
      out_symbol_r <= SIGN_CHAR;
      out_last_r   <= 1'b0;
    end else if (load_digit) begin
      out_symbol_r <= rd_symbol;
      out_last_r   <= (cnt_r == CNT_W'(1));
    end
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_symbol_r;
  assign out_ch.last   = out_last_r;

  `ITSB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_DIGITS), "digit count overflow")
  `ITSB_ASSERT_NOW(a_done_in_div, div_rsp.done, state_r == S_DIV,
                   "divider result outside digit phase")
  `ITSB_ASSERT_NOW(a_emit_nonempty, state_r == S_EMIT, cnt_r != '0,
                   "emitting from an empty digit stack")
  `ITSB_ASSERT_NEXT(a_last_to_idle, load_digit && cnt_r == CNT_W'(1),
                    state_r == S_IDLE && out_valid_r && out_last_r,
                    "final character did not close the item")

endmodule
